/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* src/adeg_pkg.sv */
// ---------------------------------------------------------------------------
// adeg_pkg
// Constants, types and helpers for the algebraic degree block.
// ---------------------------------------------------------------------------
package adeg_pkg;

    localparam int MAX_INPUTS = 12;
    localparam int WORD_BITS  = 64;

    localparam int ADDR_W  = MAX_INPUTS;
    localparam int DEPTH   = 1 << MAX_INPUTS;
    localparam int CNT_W   = MAX_INPUTS + 1;
    localparam int PASS_W  = $clog2(MAX_INPUTS + 1);
    localparam int DEG_W   = 4;
    localparam int DEG_MAX = (MAX_INPUTS > 15) ? 15 : MAX_INPUTS;

    localparam int NIN_W      = 4;
    localparam int NOUT_W     = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [NIN_W-1:0]  NIN_RESET  = 4'd12;
    localparam logic [NOUT_W-1:0] NOUT_RESET = 7'd64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_INPUTS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_OUTPUTS = 1'd1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_GAP,
        ST_PASS,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } adeg_state_t;

    // read-to-write pipeline slot
    typedef struct packed {
        logic              valid;
        logic              is_scan;
        logic [ADDR_W-1:0] addr;
    } adeg_pipe_t;

    // ones count of an index, saturated to the output width
    function automatic logic [DEG_W-1:0] index_weight(input logic [ADDR_W-1:0] x);
        int cnt;
        cnt = 0;
        for (int b = 0; b < ADDR_W; b++)
        begin
            cnt = cnt + int'(x[b]);
        end
        if (cnt > 15)
        begin
            cnt = 15;
        end
        return DEG_W'(cnt);
    endfunction

endpackage

/* src/anf_algebraic_degree_top.sv */
// ---------------------------------------------------------------------------
// anf_algebraic_degree_top
// Loads a multi-output truth table, runs the Moebius transform in place and
// reports the highest algebraic degree over the selected outputs.
// ---------------------------------------------------------------------------
// Words are taken one per cycle, while the block is loading and no register
// write is offered, into a 2^MAX_INPUTS x 64 table memory; the 2^n-th word
// closes the table. The transform then makes n passes, each one reading a pair
// of entries and writing their XOR back once per cycle through the single write
// port, with a turnaround state (ST_GAP) ahead of each pass and of the scan,
// and a scan reads every entry once more. The table memory has one write and two
// read ports. Words are refused from the end of loading until the result is
// handed to the output register; a finished result waiting there does not hold
// up loading of the next table. Any register write restarts the table load, and
// words are held off in the cycle that a register write is offered.
module anf_algebraic_degree_top
    import adeg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  truth_valid,
    output logic                  truth_stall,
    input  logic [WORD_BITS-1:0]  truth_word,

    output logic                  degree_valid,
    input  logic                  degree_stall,
    output logic [DEG_W-1:0]      max_degree
);

    logic [WORD_BITS-1:0] table_mem [DEPTH];
    logic [WORD_BITS-1:0] rd_a_reg;
    logic [WORD_BITS-1:0] rd_b_reg;

    adeg_state_t          state_reg, state_next;
    logic [NIN_W-1:0]     num_inputs_reg, num_inputs_next;
    logic [NOUT_W-1:0]    num_outputs_reg, num_outputs_next;
    logic [CNT_W-1:0]     load_count_reg, load_count_next;
    logic [PASS_W-1:0]    pass_reg, pass_next;
    logic [ADDR_W-1:0]    pair_reg, pair_next;
    logic [ADDR_W-1:0]    scan_reg, scan_next;
    logic [DEG_W-1:0]     degree_reg, degree_next;
    logic [DEG_W-1:0]     out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;
    adeg_pipe_t           pipe_reg, pipe_next;

    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [ADDR_W-1:0]    raddr_a;
    logic [ADDR_W-1:0]    raddr_b;

    logic [PASS_W-1:0]    n_eff;
    logic [CNT_W-1:0]     size;
    logic [CNT_W-1:0]     half_last;
    logic [CNT_W-1:0]     size_last;
    logic [WORD_BITS-1:0] keep;
    logic [ADDR_W-1:0]    bit_mask;
    logic [ADDR_W-1:0]    low_mask;
    logic [ADDR_W-1:0]    upper_x;
    logic [DEG_W-1:0]     weight;

    assign cfg_ready    = (state_reg == ST_LOAD);
    // a register write takes the cycle, so hold off words meanwhile
    assign truth_stall  = (state_reg != ST_LOAD) || cfg_valid;
    assign degree_valid = out_valid_reg;
    assign max_degree   = out_reg;

    // clamp the register values to what the table can hold
    always_comb
    begin
        if (int'(num_inputs_reg) > MAX_INPUTS)
        begin
            n_eff = PASS_W'(MAX_INPUTS);
        end
        else
        begin
            n_eff = PASS_W'(num_inputs_reg);
        end
        if (int'(num_outputs_reg) >= WORD_BITS)
        begin
            keep = '1;
        end
        else
        begin
            keep = (WORD_BITS'(1) << num_outputs_reg) - WORD_BITS'(1);
        end
    end

    assign size      = CNT_W'(1) << n_eff;
    assign half_last = (size >> 1) - CNT_W'(1);
    assign size_last = size - CNT_W'(1);

    // place a one at bit position pass_reg inside the pair index
    assign bit_mask = ADDR_W'(1) << pass_reg;
    assign low_mask = bit_mask - ADDR_W'(1);
    assign upper_x  = ((pair_reg & ~low_mask) << 1) | bit_mask | (pair_reg & low_mask);

    assign weight = index_weight(pipe_reg.addr);

    // table memory: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        rd_a_reg <= table_mem[raddr_a];
        rd_b_reg <= table_mem[raddr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_LOAD;
            num_inputs_reg  <= NIN_RESET;
            num_outputs_reg <= NOUT_RESET;
            load_count_reg  <= '0;
            pass_reg        <= '0;
            pair_reg        <= '0;
            scan_reg        <= '0;
            degree_reg      <= '0;
            out_valid_reg   <= 1'b0;
            pipe_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            num_inputs_reg  <= num_inputs_next;
            num_outputs_reg <= num_outputs_next;
            load_count_reg  <= load_count_next;
            pass_reg        <= pass_next;
            pair_reg        <= pair_next;
            scan_reg        <= scan_next;
            degree_reg      <= degree_next;
            out_valid_reg   <= out_valid_next;
            pipe_reg        <= pipe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        num_inputs_next  = num_inputs_reg;
        num_outputs_next = num_outputs_reg;
        load_count_next  = load_count_reg;
        pass_next        = pass_reg;
        pair_next        = pair_reg;
        scan_next        = scan_reg;
        degree_next      = degree_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg;
        pipe_next        = '0;
        mem_we           = 1'b0;
        mem_waddr        = pipe_reg.addr;
        mem_wdata        = rd_a_reg ^ rd_b_reg;
        raddr_a          = '0;
        raddr_b          = '0;

        // retire the slot read last cycle
        if (pipe_reg.valid && !pipe_reg.is_scan)
        begin
            mem_we = 1'b1;
        end
        if (pipe_reg.valid && pipe_reg.is_scan && ((rd_a_reg & keep) != '0)
            && (weight > degree_reg))
        begin
            degree_next = weight;
        end

        if (out_valid_reg && !degree_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (cfg_valid)
                begin
                    load_count_next = '0;
                    if (cfg_index == REG_NUM_INPUTS)
                    begin
                        num_inputs_next = cfg_data[NIN_W-1:0];
                    end
                    else if (cfg_index == REG_NUM_OUTPUTS)
                    begin
                        num_outputs_next = cfg_data[NOUT_W-1:0];
                    end
                end
                else if (truth_valid)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = load_count_reg[ADDR_W-1:0];
                    mem_wdata = truth_word;
                    if (load_count_reg == size_last)
                    begin
                        load_count_next = '0;
                        pass_next       = '0;
                        pair_next       = '0;
                        scan_next       = '0;
                        degree_next     = '0;
                        state_next      = ST_GAP;
                    end
                    else
                    begin
                        load_count_next = load_count_reg + CNT_W'(1);
                    end
                end
            end
            ST_GAP:
            begin
                // let the last write of a pass land before the next reads
                if (pass_reg == n_eff)
                begin
                    state_next = ST_SCAN;
                end
                else
                begin
                    state_next = ST_PASS;
                end
            end
            ST_PASS:
            begin
                raddr_a           = upper_x;
                raddr_b           = upper_x ^ bit_mask;
                pipe_next.valid   = 1'b1;
                pipe_next.is_scan = 1'b0;
                pipe_next.addr    = upper_x;
                if (pair_reg == half_last[ADDR_W-1:0])
                begin
                    pair_next  = '0;
                    pass_next  = pass_reg + PASS_W'(1);
                    state_next = ST_GAP;
                end
                else
                begin
                    pair_next = pair_reg + ADDR_W'(1);
                end
            end
            ST_SCAN:
            begin
                raddr_a           = scan_reg;
                pipe_next.valid   = 1'b1;
                pipe_next.is_scan = 1'b1;
                pipe_next.addr    = scan_reg;
                if (scan_reg == size_last[ADDR_W-1:0])
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_next = scan_reg + ADDR_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !degree_stall)
                begin
                    out_valid_next = 1'b1;
                    out_next       = degree_reg;
                    state_next     = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

/* src/adeg_checker.sv */
// ---------------------------------------------------------------------------
// adeg_checker
// Port-level checks for the algebraic degree block, bound to its top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module adeg_checker
    import adeg_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic                  truth_stall,
    input logic                  degree_valid,
    input logic                  degree_stall,
    input logic [DEG_W-1:0]      max_degree
);

    // a degree never exceeds DEG_MAX, the most inputs a table can have
    `ASSERT_IMPL(a_degree_bound, clk, rst_n, degree_valid, max_degree <= DEG_W'(DEG_MAX))

    // a stalled result holds
    `ASSERT_NEXT(a_result_hold, clk, rst_n, degree_valid && degree_stall, degree_valid && $stable(max_degree))

    // a register write never shares an edge with a word
    `ASSERT_IMPL(a_cfg_phase, clk, rst_n, cfg_valid && cfg_ready, truth_stall)

    // a result appears only after the transform has held off input
    `ASSERT_IMPL(a_result_after_work, clk, rst_n, $rose(degree_valid), $past(truth_stall))

endmodule

bind anf_algebraic_degree_top adeg_checker u_adeg_checker (.*);

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Streams truth tables into the algebraic degree block under several input
// and output counts, predicts each degree from its own ANF transform and
// compares every returned degree with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module testbench;
    import adeg_pkg::*;

    localparam int LIMIT      = 2_000_000;
    localparam int RAND_WORDS = 560;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_NUM_INPUTS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  truth_valid = 1'b0;
    logic                  truth_stall;
    logic [WORD_BITS-1:0]  truth_word = '0;
    logic                  degree_valid;
    logic                  degree_stall = 1'b0;
    logic [DEG_W-1:0]      max_degree;

    // predictor state
    logic [WORD_BITS-1:0] coeff_store [0:DEPTH-1];
    int                   fill_count = 0;
    logic [NIN_W-1:0]     cur_inputs = NIN_RESET;
    logic [NOUT_W-1:0]    cur_outputs = NOUT_RESET;

    logic [WORD_BITS-1:0] word_backlog [$];
    logic [DEG_W-1:0]     degree_due [$];
    int                   idle_pct = 31;
    int                   fault_count = 0;
    int                   cycle_count = 0;

    anf_algebraic_degree_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .truth_valid  (truth_valid),
        .truth_stall  (truth_stall),
        .truth_word   (truth_word),
        .degree_valid (degree_valid),
        .degree_stall (degree_stall),
        .max_degree   (max_degree)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Store one accepted word; on the closing word of a table, fold it into
    // ANF coefficients and queue the highest weight of a surviving index.
    task automatic absorb_truth_word(input logic [WORD_BITS-1:0] word);
        int                   n;
        int                   size;
        int                   best;
        int                   i;
        int                   x;
        logic [WORD_BITS-1:0] keep;
        n = (cur_inputs > MAX_INPUTS) ? MAX_INPUTS : int'(cur_inputs);
        size = 1 << n;
        keep = (cur_outputs >= WORD_BITS) ? '1 : ((64'd1 << cur_outputs) - 64'd1);
        coeff_store[fill_count] = word;
        fill_count++;
        if (fill_count < size)
        begin
            return;
        end
        fill_count = 0;
        for (i = 0; i < n; i++)
        begin
            for (x = 0; x < size; x++)
            begin
                if (x & (1 << i))
                begin
                    coeff_store[x] ^= coeff_store[x ^ (1 << i)];
                end
            end
        end
        best = 0;
        for (x = 0; x < size; x++)
        begin
            if ((coeff_store[x] & keep) != '0 && $countones(x) > best)
            begin
                best = $countones(x);
            end
        end
        degree_due.push_back((best > 15) ? DEG_W'(15) : DEG_W'(best));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_NUM_INPUTS)
        begin
            cur_inputs = data[NIN_W-1:0];
        end
        else
        begin
            cur_outputs = data;
        end
        // any write restarts the table load
        fill_count = 0;
    endtask

    // Queue one table: a sum of up to four monomials over random output
    // lanes, or plain noise, or a constant map.
    task automatic queue_table(input int n, input int d, input int kind);
        logic [WORD_BITS-1:0] konst;
        logic [WORD_BITS-1:0] word;
        logic [WORD_BITS-1:0] lanes [4];
        logic [ADDR_W-1:0]    mono [4];
        int                   terms;
        int                   k;
        int                   x;
        terms = $urandom_range(4, 1);
        konst = $urandom_range(1) ? {$urandom, $urandom} : '0;
        for (k = 0; k < 4; k++)
        begin
            lanes[k] = $urandom_range(1) ? {$urandom, $urandom}
                                         : (64'd1 << $urandom_range(63));
            mono[k] = ADDR_W'($urandom) & ADDR_W'((1 << n) - 1);
            while ($countones(mono[k]) > d)
            begin
                mono[k] = mono[k] & (mono[k] - 1'b1);
            end
        end
        // make the leading term reach the target degree
        while ($countones(mono[0]) < d)
        begin
            mono[0][$urandom_range(n - 1, 0)] = 1'b1;
        end
        for (x = 0; x < (1 << n); x++)
        begin
            word = konst;
            for (k = 0; k < terms; k++)
            begin
                if ((ADDR_W'(x) & mono[k]) == mono[k])
                begin
                    word ^= lanes[k];
                end
            end
            if (kind == 1)
            begin
                word = {$urandom, $urandom};
            end
            else if (kind == 2)
            begin
                word = konst;
            end
            word_backlog.push_back(word);
        end
    endtask

    // Wait until every word is taken and every degree has come back; look
    // between edges so the driver's updates have settled.
    task automatic drain_all(input int settle);
        do
            @(negedge clk);
        while (word_backlog.size() != 0 || truth_valid || degree_due.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    // driver: hold a stalled transaction, otherwise advance or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            truth_valid <= 1'b0;
        end
        else
        begin
            if (truth_valid && !truth_stall)
            begin
                absorb_truth_word(truth_word);
            end
            if (!truth_valid || !truth_stall)
            begin
                if (word_backlog.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    truth_valid <= 1'b1;
                    truth_word  <= word_backlog.pop_front();
                end
                else
                begin
                    truth_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_stall <= 1'b0;
        end
        else
        begin
            if (degree_valid && !degree_stall)
            begin
                if (degree_due.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                    begin
                        $display("unexpected degree %0d", max_degree);
                    end
                end
                else if (degree_due[0] !== max_degree)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                    begin
                        $display("max_degree mismatch: expected %0d, actual %0d",
                                 degree_due[0], max_degree);
                    end
                    void'(degree_due.pop_front());
                end
                else
                begin
                    void'(degree_due.pop_front());
                end
            end
            degree_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int phase;
        int n;
        int size;
        int pick;
        int rand_words;
        int rand_tables;
        logic [NOUT_W-1:0] m;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // zero inputs: every word is a table of its own; upper data bits dropped
        write_reg(REG_NUM_INPUTS, 7'h70);
        write_reg(REG_NUM_OUTPUTS, 7'd64);
        word_backlog.push_back('0);
        word_backlog.push_back('1);
        word_backlog.push_back(64'd1 << 63);
        word_backlog.push_back(64'd1);
        drain_all(20);

        // output count above the word width
        write_reg(REG_NUM_INPUTS, 7'd1);
        write_reg(REG_NUM_OUTPUTS, 7'd127);
        word_backlog.push_back('0);
        word_backlog.push_back(64'd1 << 63);
        drain_all(20);

        // one output: bit 0 is x0 AND x1, bit 63 is x0 and gets masked
        write_reg(REG_NUM_INPUTS, 7'd2);
        write_reg(REG_NUM_OUTPUTS, 7'd1);
        word_backlog.push_back('0);
        word_backlog.push_back(64'd1 << 63);
        word_backlog.push_back('0);
        word_backlog.push_back((64'd1 << 63) | 64'd1);
        drain_all(20);

        // zero outputs mask everything away
        write_reg(REG_NUM_OUTPUTS, 7'd0);
        queue_table(2, 2, 1);
        drain_all(20);

        // a register write in the middle of a load throws the partial table away
        write_reg(REG_NUM_INPUTS, 7'd3);
        write_reg(REG_NUM_OUTPUTS, 7'd64);
        repeat (3) word_backlog.push_back({$urandom, $urandom});
        drain_all(20);
        write_reg(REG_NUM_OUTPUTS, 7'd64);
        queue_table(3, 3, 0);
        drain_all(20);

        // input count above the maximum is clamped: a short load closes no table
        write_reg(REG_NUM_INPUTS, 7'h0F);
        repeat (64) word_backlog.push_back({$urandom, $urandom});
        drain_all(20);

        phase = 0;
        rand_words = 0;
        rand_tables = 0;
        while (rand_words < RAND_WORDS || rand_tables < 40)
        begin
            phase++;
            idle_pct = (phase >= 8 && phase < 16) ? 0 : 31;
            n = ($urandom_range(99) < 25) ? 0 : $urandom_range(6, 1);
            size = 1 << n;
            pick = $urandom_range(9);
            case (pick)
                0: m = 7'd0;
                1: m = 7'd1;
                2: m = 7'd63;
                3: m = 7'd64;
                4: m = 7'd65;
                5: m = 7'd127;
                default: m = NOUT_W'($urandom_range(127));
            endcase
            if ($urandom_range(1))
            begin
                write_reg(REG_NUM_OUTPUTS, m);
                write_reg(REG_NUM_INPUTS, {3'($urandom), 4'(n)});
            end
            else
            begin
                write_reg(REG_NUM_INPUTS, {3'($urandom), 4'(n)});
                write_reg(REG_NUM_OUTPUTS, m);
            end
            repeat ($urandom_range(3, 1))
            begin
                pick = $urandom_range(99);
                queue_table(n, $urandom_range(n, 0), (pick < 10) ? 1 : (pick < 18) ? 2 : 0);
                rand_words += size;
                rand_tables++;
            end
            // now and then leave a table unfinished for the next write to drop
            if (n > 0 && $urandom_range(9) == 0)
            begin
                repeat ($urandom_range(size - 1, 1)) word_backlog.push_back({$urandom, $urandom});
            end
            drain_all(20);
        end

        drain_all(64);
        if (fault_count == 0 && degree_due.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
